// File: rtl/bls_pkg.sv
package bls_pkg;

  // Field widths
  localparam int unsigned VOLT_W  = 8;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned WIN_W   = 6;
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Serial divider geometry: 15-bit dividend, 8-bit divisor, one bit per step
  localparam int unsigned DVD_W     = 15;
  localparam int unsigned DSR_W     = 8;
  localparam int unsigned DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [SUM_W-1:0] SUM_MAX   = 14'd16383;
  localparam logic [WIN_W-1:0] WIN_MAX   = 6'd63;

  // Register defaults
  localparam logic [7:0]       EMPTY_RST = 8'd99;
  localparam logic [7:0]       FULL_RST  = 8'd126;
  localparam logic [WIN_W-1:0] WIN_RST   = 6'd25;
  localparam logic [PCT_W-1:0] LOW_RST   = 7'd10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PCT_DIV,
    ST_UPDATE,
    ST_AVG_DIV,
    ST_FINISH
  } bls_state_t;

endpackage

// File: rtl/bls_in_if.sv
interface bls_in_if;
  import bls_pkg::*;

  logic               valid;
  logic               ready;
  logic [VOLT_W-1:0]  voltage;
  logic               reading_ok;

  modport source (output valid, output voltage, output reading_ok, input ready);
  modport sink   (input valid, input voltage, input reading_ok, output ready);
endinterface

// File: rtl/bls_out_if.sv
interface bls_out_if;
  import bls_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] level_percent;
  logic [PCT_W-1:0]          sample_percent;
  logic                      filling;
  logic                      signal_lost;
  logic                      shutdown;

  modport source (output valid, output level_percent, output sample_percent,
                  output filling, output signal_lost, output shutdown, input ready);
  modport sink   (input valid, input level_percent, input sample_percent,
                  input filling, input signal_lost, input shutdown, output ready);
endinterface

// File: rtl/battery_level_smoother_top.sv
// Sequencing: a transaction is accepted in ST_IDLE, then passes an optional percentage
//   division (ST_PCT_DIV), ST_UPDATE, an optional average division (ST_AVG_DIV) and
//   ST_FINISH, which waits until the output register is free. A new transaction is
//   accepted only in ST_IDLE, after the previous one is finished; the 15-step serial
//   divider is shared by the percentage and the average calculation.
// Reset: synchronous, active-low rst_n; configuration and gauge registers return to
//   their defaults and the gauge starts a fresh fill window with shutdown cleared.
module battery_level_smoother_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  bls_in_if.sink                               in_ch,
  bls_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [bls_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [bls_pkg::CFG_W-1:0]            cfg_data
);
  import bls_pkg::*;

  // Sequencer state
  bls_state_t state_r, state_nxt;

  // Configuration registers
  logic [7:0]       empty_r, full_r;
  logic [WIN_W-1:0] win_r;
  logic [PCT_W-1:0] low_r;

  // Gauge state
  logic                      fill_r, fill_nxt;
  logic [WIN_W-1:0]          fcnt_r, fcnt_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [WIN_W-1:0]          dvs_r, dvs_nxt;
  logic signed [LEVEL_W-1:0] avg_r, avg_nxt;
  logic [WIN_W-1:0]          bad_r, bad_nxt;
  logic                      halted_r, halted_nxt;

  // Per-transaction working registers
  logic             ok_r, ok_nxt;
  logic [PCT_W-1:0] pct_r, pct_nxt;
  logic             filling_r, filling_nxt;
  logic             lost_r, lost_nxt;

  // Shared serial divider
  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [DSR_W-1:0]     rem_r, rem_nxt;
  logic [DSR_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [DSR_W:0]       trial;
  logic                 trial_ge;
  logic [DSR_W:0]       rem_step;
  logic [DVD_W-1:0]     quo_step;
  logic [PCT_W-1:0]     quo_clamped;

  // Output register
  logic                      out_valid_r, out_valid_nxt;
  logic signed [LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic [PCT_W-1:0]          out_pct_r, out_pct_nxt;
  logic                      out_fill_r, out_fill_nxt;
  logic                      out_lost_r, out_lost_nxt;
  logic                      out_shut_r, out_shut_nxt;

  // Update-step helpers
  logic [WIN_W-1:0] eff_win;
  logic             good;
  logic [DVD_W-1:0] sum_add;
  logic [DVD_W-1:0] run_sum;
  logic [DVD_W-1:0] avg_ext;
  logic [DVD_W-1:0] run_diff;
  logic [SUM_W-1:0] sum_sat;
  logic [SUM_W-1:0] run_sat;
  logic [WIN_W-1:0] div_f, cnt_f, bad_inc;
  logic [7:0]       span, vdelta;
  logic             avg_pos;

  // A window of zero behaves as one sample
  assign eff_win = (win_r == '0) ? WIN_W'(1) : win_r;
  assign good    = ok_r && (pct_r != '0);
  assign avg_pos = !avg_r[LEVEL_W-1] && (avg_r != '0);

  assign span    = full_r - empty_r;
  assign vdelta  = in_ch.voltage - empty_r;

  // Fill arithmetic: add the sample, saturate the sum
  assign sum_add = DVD_W'(sum_r) + DVD_W'(pct_r);
  assign sum_sat = sum_add[DVD_W-1] ? SUM_MAX : sum_add[SUM_W-1:0];

  // Running arithmetic: sum + new - average, floored at zero, then saturated
  assign avg_ext  = DVD_W'(avg_r[PCT_W-1:0]);
  assign run_sum  = sum_add;
  assign run_diff = (run_sum > avg_ext) ? (run_sum - avg_ext) : '0;
  assign run_sat  = run_diff[DVD_W-1] ? SUM_MAX : run_diff[SUM_W-1:0];

  assign div_f   = (!ok_r && dvs_r != '0) ? dvs_r - WIN_W'(1) : dvs_r;
  assign cnt_f   = (fcnt_r < WIN_MAX) ? fcnt_r + WIN_W'(1) : fcnt_r;
  assign bad_inc = bad_r + WIN_W'(1);

  // One restoring-division step: shift in the next dividend bit, trial subtract
  assign trial       = {rem_r, quo_r[DVD_W-1]};
  assign trial_ge    = trial >= {1'b0, dsr_r};
  assign rem_step    = trial_ge ? (trial - {1'b0, dsr_r}) : trial;
  assign quo_step    = {quo_r[DVD_W-2:0], trial_ge};
  assign quo_clamped = (quo_step > DVD_W'(PCT_FULL)) ? PCT_FULL : quo_step[PCT_W-1:0];

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.level_percent = out_level_r;
  assign out_ch.sample_percent = out_pct_r;
  assign out_ch.filling       = out_fill_r;
  assign out_ch.signal_lost   = out_lost_r;
  assign out_ch.shutdown      = out_shut_r;

  // Next state and datapath control
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    fcnt_nxt    = fcnt_r;
    sum_nxt     = sum_r;
    dvs_nxt     = dvs_r;
    avg_nxt     = avg_r;
    bad_nxt     = bad_r;
    halted_nxt  = halted_r;
    ok_nxt      = ok_r;
    pct_nxt     = pct_r;
    filling_nxt = filling_r;
    lost_nxt    = lost_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dsr_nxt     = dsr_r;
    dcnt_nxt    = dcnt_r;

    // Drop the held result once the sink takes it
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_level_nxt = out_level_r;
    out_pct_nxt   = out_pct_r;
    out_fill_nxt  = out_fill_r;
    out_lost_nxt  = out_lost_r;
    out_shut_nxt  = out_shut_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          ok_nxt      = in_ch.reading_ok;
          filling_nxt = 1'b0;
          lost_nxt    = 1'b0;
          if (in_ch.reading_ok && (full_r > empty_r) && (in_ch.voltage > empty_r)) begin
            // Start the percentage division: (v - empty) * 100 / span
            quo_nxt   = DVD_W'(vdelta) * DVD_W'(PCT_FULL);
            rem_nxt   = '0;
            dsr_nxt   = span;
            dcnt_nxt  = '0;
            state_nxt = ST_PCT_DIV;
          end else begin
            // Failed read, at or below empty, or a degenerate span
            pct_nxt   = (in_ch.reading_ok && (full_r <= empty_r) &&
                         (in_ch.voltage > empty_r)) ? PCT_FULL : '0;
            state_nxt = ST_UPDATE;
          end
        end
      end

      ST_PCT_DIV: begin
        quo_nxt  = quo_step;
        rem_nxt  = rem_step[DSR_W-1:0];
        dcnt_nxt = dcnt_r + DIV_CNT_W'(1);
        if (dcnt_r == DIV_LAST) begin
          pct_nxt   = quo_clamped;
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        state_nxt = ST_FINISH;
        if (fill_r) begin
          filling_nxt = 1'b1;
          if (good) sum_nxt = sum_sat;
          dvs_nxt  = div_f;
          fcnt_nxt = cnt_f;
          if (cnt_f >= eff_win) begin
            fill_nxt = 1'b0;
            if (div_f == '0) begin
              avg_nxt = -LEVEL_W'(1);
            end else begin
              quo_nxt   = DVD_W'(good ? sum_sat : sum_r);
              rem_nxt   = '0;
              dsr_nxt   = DSR_W'(div_f);
              dcnt_nxt  = '0;
              state_nxt = ST_AVG_DIV;
            end
          end
        end else if (avg_pos) begin
          if (good) begin
            sum_nxt = run_sat;
            bad_nxt = '0;
            if (dvs_r == '0) begin
              avg_nxt = '0;
            end else begin
              quo_nxt   = DVD_W'(run_sat);
              rem_nxt   = '0;
              dsr_nxt   = DSR_W'(dvs_r);
              dcnt_nxt  = '0;
              state_nxt = ST_AVG_DIV;
            end
          end else if (bad_r < WIN_MAX) begin
            bad_nxt = bad_inc;
            if (bad_inc == eff_win) begin
              lost_nxt = 1'b1;
              avg_nxt  = '0;
            end
          end
        end else if (good) begin
          // Good sample with no valid average: open a fresh fill
          fill_nxt    = 1'b1;
          fcnt_nxt    = '0;
          sum_nxt     = '0;
          dvs_nxt     = eff_win;
          avg_nxt     = '0;
          bad_nxt     = '0;
          filling_nxt = 1'b1;
        end
      end

      ST_AVG_DIV: begin
        quo_nxt  = quo_step;
        rem_nxt  = rem_step[DSR_W-1:0];
        dcnt_nxt = dcnt_r + DIV_CNT_W'(1);
        if (dcnt_r == DIV_LAST) begin
          avg_nxt   = LEVEL_W'(quo_clamped);
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // Hold until the output register is free, then load the result
        if (!out_valid_r || out_ch.ready) begin
          halted_nxt    = halted_r || (avg_pos && (avg_r[PCT_W-1:0] < low_r));
          out_valid_nxt = 1'b1;
          out_level_nxt = avg_r;
          out_pct_nxt   = pct_r;
          out_fill_nxt  = filling_r;
          out_lost_nxt  = lost_r;
          out_shut_nxt  = halted_nxt;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and gauge registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      empty_r     <= EMPTY_RST;
      full_r      <= FULL_RST;
      win_r       <= WIN_RST;
      low_r       <= LOW_RST;
      fill_r      <= 1'b1;
      fcnt_r      <= '0;
      sum_r       <= '0;
      dvs_r       <= WIN_RST;
      avg_r       <= '0;
      bad_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      fcnt_r      <= fcnt_nxt;
      sum_r       <= sum_nxt;
      dvs_r       <= dvs_nxt;
      avg_r       <= avg_nxt;
      bad_r       <= bad_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_EMPTY_LEVEL: empty_r <= cfg_data;
          REG_FULL_LEVEL:  full_r  <= cfg_data;
          REG_WINDOW_SIZE: win_r   <= cfg_data[WIN_W-1:0];
          REG_LOW_LIMIT:   low_r   <= cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: divider, working values, result
  always_ff @(posedge clk) begin
    ok_r        <= ok_nxt;
    pct_r       <= pct_nxt;
    filling_r   <= filling_nxt;
    lost_r      <= lost_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    dsr_r       <= dsr_nxt;
    dcnt_r      <= dcnt_nxt;
    out_level_r <= out_level_nxt;
    out_pct_r   <= out_pct_nxt;
    out_fill_r  <= out_fill_nxt;
    out_lost_r  <= out_lost_nxt;
    out_shut_r  <= out_shut_nxt;
  end

  // Shutdown is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("shutdown flag cleared without reset");

  // A fill transaction never reports signal loss
  a_fill_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_fill_r && out_lost_r))
    else $error("filling and signal_lost both set");

  // Results stay within their ranges
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pct_r <= PCT_FULL) &&
                    ((out_level_r == -LEVEL_W'(1)) ||
                     (!out_level_r[LEVEL_W-1] && out_level_r[PCT_W-1:0] <= PCT_FULL)))
    else $error("result field out of range");

  // A percentage division always starts from step zero
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != ST_PCT_DIV) && (state_nxt == ST_PCT_DIV)) |=> (dcnt_r == '0))
    else $error("divider started mid-count");

  // Shutdown reported alongside an average below the limit
  a_shut_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && (!out_valid_r || out_ch.ready) && avg_pos &&
     avg_r[PCT_W-1:0] < low_r) |=> (out_shut_r && halted_r))
    else $error("low average did not raise shutdown");

endmodule

// File: tb/battery_level_smoother_top_tb.sv
`timescale 1ns / 100ps

module battery_level_smoother_top_tb;
  import bls_pkg::*;

  // One result transaction as the gauge reports it
  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic [PCT_W-1:0]          sample;
    logic                      filling;
    logic                      lost;
    logic                      shutdown;
  } gauge_result_t;

  // Mirror of the gauge: register copies, averaging state and the queue of
  // results still owed by the block, oldest first.
  class gauge_scoreboard;
    logic [VOLT_W-1:0]        empty_lvl;
    logic [VOLT_W-1:0]        full_lvl;
    logic [WIN_W-1:0]         win_reg;
    logic [PCT_W-1:0]         low_lim;
    bit                       fill_phase;
    logic [WIN_W-1:0]         fill_cnt;
    logic [SUM_W-1:0]         sum;
    logic [WIN_W-1:0]         div;
    logic signed [LEVEL_W-1:0] avg;
    logic [WIN_W-1:0]         bad_run;
    bit                       halted;
    gauge_result_t            owed_q[$];
    int                       errors;
    int                       results_seen;
    int                       lost_seen;

    function new();
      empty_lvl = EMPTY_RST;
      full_lvl  = FULL_RST;
      win_reg   = WIN_RST;
      low_lim   = LOW_RST;
      halted    = 1'b0;
      errors    = 0;
      results_seen = 0;
      lost_seen = 0;
      start_fill();
    endfunction

    function int unsigned window_eff();
      return (win_reg == '0) ? 1 : 32'(win_reg);
    endfunction

    function void start_fill();
      fill_phase = 1'b1;
      fill_cnt   = '0;
      sum        = '0;
      div        = WIN_W'(window_eff());
      avg        = '0;
      bad_run    = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_EMPTY_LEVEL: empty_lvl = data;
        REG_FULL_LEVEL:  full_lvl  = data;
        REG_WINDOW_SIZE: win_reg   = data[WIN_W-1:0];
        REG_LOW_LIMIT:   low_lim   = data[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned percent_of(logic [VOLT_W-1:0] v);
      int unsigned vi, ei, fi, q;
      vi = 32'(v);
      ei = 32'(empty_lvl);
      fi = 32'(full_lvl);
      if (fi <= ei) return (vi > ei) ? 100 : 0;
      if (vi <= ei) return 0;
      q = ((vi - ei) * 100) / (fi - ei);
      return (q > 100) ? 100 : q;
    endfunction

    function logic signed [LEVEL_W-1:0] mean_of(int unsigned s, int unsigned d);
      int unsigned q;
      if (d == 0) return LEVEL_W'(-1);
      q = s / d;
      return LEVEL_W'((q > 100) ? 100 : q);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Advance the mirror by one accepted sample and queue the result it owes
    function void note_sample(logic [VOLT_W-1:0] v, logic ok);
      int unsigned   p, s, a;
      bit            good, filling, lost;
      gauge_result_t r;
      p       = ok ? percent_of(v) : 0;
      good    = ok && (p > 0);
      filling = 1'b0;
      lost    = 1'b0;
      if (fill_phase) begin
        filling = 1'b1;
        if (good) begin
          s   = sum + p;
          sum = SUM_W'((s > SUM_MAX) ? SUM_MAX : s);
        end
        if (!ok && div > 0) div = div - WIN_W'(1);
        if (fill_cnt < WIN_MAX) fill_cnt = fill_cnt + WIN_W'(1);
        if (fill_cnt >= window_eff()) begin
          fill_phase = 1'b0;
          avg = mean_of(32'(sum), 32'(div));
        end
      end else if (avg > 0) begin
        if (good) begin
          s = sum + p;
          a = 32'(avg[PCT_W-1:0]);
          s = (s > a) ? s - a : 0;
          if (s > SUM_MAX) s = SUM_MAX;
          sum     = SUM_W'(s);
          avg     = (div == '0) ? '0 : mean_of(32'(sum), 32'(div));
          bad_run = '0;
        end else if (bad_run < WIN_MAX) begin
          bad_run = bad_run + WIN_W'(1);
          if (bad_run == window_eff()) begin
            lost = 1'b1;
            avg  = '0;
          end
        end
      end else if (good) begin
        start_fill();
        filling = 1'b1;
      end
      if (avg > 0 && int'(avg) < int'(low_lim)) halted = 1'b1;
      r.level    = avg;
      r.sample   = p[PCT_W-1:0];
      r.filling  = filling;
      r.lost     = lost;
      r.shutdown = halted;
      owed_q.insert(owed_q.size(), r);
    endfunction

    function void check_result(gauge_result_t got);
      gauge_result_t exp_r;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result level=%0d sample=%0d fill=%0b lost=%0b shut=%0b",
                 $time, got.level, got.sample, got.filling, got.lost, got.shutdown);
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      results_seen++;
      if (exp_r.lost) lost_seen++;
      if (got.level !== exp_r.level) begin
        $display("%0t: level_percent expected %0d got %0d", $time, exp_r.level, got.level);
        errors++;
      end
      if (got.sample !== exp_r.sample) begin
        $display("%0t: sample_percent expected %0d got %0d", $time, exp_r.sample, got.sample);
        errors++;
      end
      if (got.filling !== exp_r.filling) begin
        $display("%0t: filling expected %0b got %0b", $time, exp_r.filling, got.filling);
        errors++;
      end
      if (got.lost !== exp_r.lost) begin
        $display("%0t: signal_lost expected %0b got %0b", $time, exp_r.lost, got.lost);
        errors++;
      end
      if (got.shutdown !== exp_r.shutdown) begin
        $display("%0t: shutdown expected %0b got %0b", $time, exp_r.shutdown, got.shutdown);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;    // extra idle time after the last result, before register writes
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to back the block up
  localparam int N_PHASES     = 10;
  localparam int N_DIRECTED   = 25;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 hold_rx = 1'b0;
  int                   stall_pct = 0;
  int                   idle_pct = 0;
  int                   cycle_count = 0;
  int                   samples_sent = 0;

  bls_in_if  in_ch ();
  bls_out_if out_ch ();

  gauge_scoreboard sb = new();

  battery_level_smoother_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Register settings per phase: reset values first, then the extremes
  // (empty at both ends, full not above empty, window of zero and of 63,
  // low limit of zero and all ones), then a spread of ordinary gauges.
  logic [CFG_W-1:0] ph_empty [N_PHASES] = '{8'd99, 8'd0, 8'd255, 8'd10, 8'd50,
                                            8'd99, 8'd120, 8'd0, 8'd60, 8'd200};
  logic [CFG_W-1:0] ph_full  [N_PHASES] = '{8'd126, 8'd255, 8'd0, 8'd20, 8'd200,
                                            8'd126, 8'd120, 8'd100, 8'd180, 8'd255};
  logic [CFG_W-1:0] ph_win   [N_PHASES] = '{8'd25, 8'd1, 8'd63, 8'd0, 8'd8,
                                            8'd5, 8'd12, 8'd63, 8'd3, 8'hC2};
  logic [CFG_W-1:0] ph_low   [N_PHASES] = '{8'd10, 8'd0, 8'd100, 8'hFF, 8'd50,
                                            8'd60, 8'd30, 8'd100, 8'd20, 8'd1};
  int               ph_mode  [N_PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 3};
  int               ph_items [N_PHASES] = '{120, 120, 60, 120, 120,
                                            120, 120, 120, 120, 120};

  // Opening samples at the reset settings: rail values, the empty and full
  // points and their neighbours, failed reads mid-fill; exactly one window long.
  logic [VOLT_W-1:0] dir_volt [N_DIRECTED] = '{8'd0, 8'd255, 8'd99, 8'd100, 8'd126,
                                               8'd127, 8'd112, 8'd200, 8'd255, 8'd0,
                                               8'd101, 8'd113, 8'd125, 8'd99, 8'd104,
                                               8'd110, 8'd120, 8'd140, 8'd100, 8'd105,
                                               8'd90, 8'd115, 8'd118, 8'd108, 8'd123};
  logic              dir_ok   [N_DIRECTED] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                               1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                                               1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                               1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
                                               1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: drop the run if the block stops answering
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycle_count, sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check each transaction against the oldest owed result,
  // then decide the next ready, held low throughout a hold-off.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{level:    out_ch.level_percent,
                        sample:   out_ch.sample_percent,
                        filling:  out_ch.filling,
                        lost:     out_ch.signal_lost,
                        shutdown: out_ch.shutdown});
    end
    out_ch.ready <= !hold_rx && ($urandom_range(99) >= stall_pct);
  end

  // Offer one sample, idling first at the current rate, and hold it until
  // the block takes the transaction.
  task automatic send_sample(input logic [VOLT_W-1:0] v, input logic ok);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.voltage    <= v;
    in_ch.reading_ok <= ok;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(v, ok);
    samples_sent++;
  endtask

  // Raise the write enable and keep it high; the caller lowers it after the
  // last write so the strobe never drops and rises within one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Wait for every owed result, then idle for the DRAIN_CYCLES stretch before touching
  // the registers.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random traffic built from runs: good runs to fill and track the average,
  // bad runs sized around the window to provoke signal loss, and short bursts
  // of noise. Near-empty voltages pull the average down towards shutdown.
  task automatic random_samples(input int n);
    int unsigned       w;
    int                sent;
    int                kind;
    int                len;
    int unsigned       near;
    logic [VOLT_W-1:0] v;
    logic              ok;
    w    = sb.window_eff();
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(9);
      len  = (kind >= 8) ? $urandom_range(4, 1) : $urandom_range(2 * w + 2, 1);
      for (int k = 0; k < len && sent < n; k++) begin
        if (kind <= 4) begin
          ok = 1'b1;
          if (sb.empty_lvl == 8'hFF) begin
            v = VOLT_W'($urandom);
          end else if ($urandom_range(3) == 0) begin
            near = sb.empty_lvl + $urandom_range(3, 1);
            v = (near > 255) ? 8'hFF : near[VOLT_W-1:0];
          end else begin
            v = VOLT_W'($urandom_range(255, sb.empty_lvl + 1));
          end
        end else if (kind <= 7) begin
          ok = 1'($urandom_range(1));
          v  = ok ? VOLT_W'($urandom_range(sb.empty_lvl, 0)) : VOLT_W'($urandom);
        end else begin
          ok = 1'($urandom_range(1));
          v  = VOLT_W'($urandom);
        end
        send_sample(v, ok);
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.voltage    = '0;
    in_ch.reading_ok = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed fill at the reset settings, no idling on either side
    for (int i = 0; i < N_DIRECTED; i++) send_sample(dir_volt[i], dir_ok[i]);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(REG_EMPTY_LEVEL, ph_empty[ph]);
      write_reg(REG_FULL_LEVEL,  ph_full[ph]);
      write_reg(REG_WINDOW_SIZE, ph_win[ph]);
      write_reg(REG_LOW_LIMIT,   ph_low[ph]);
      cfg_we <= 1'b0;

      case (ph_mode[ph])
        1:       begin idle_pct = 49; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 49; end
        3:       begin idle_pct = 17; stall_pct <= 17; end
        default: begin idle_pct = 0;  stall_pct <= 0;  end
      endcase

      // Hold the result side off for a long stretch in one phase while the
      // sender keeps offering, so the block fills and back-pressures input.
      if (ph == 4) begin
        fork
          begin
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rx <= 1'b0;
          end
        join_none
      end

      random_samples(ph_items[ph]);
      drain();
    end

    $display("Run covered %0d samples over %0d register settings and the reset values",
             samples_sent, N_PHASES);
    $display("%0d results checked, %0d signal-loss reports, shutdown raised: %0b",
             sb.results_seen, sb.lost_seen, sb.halted);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
